// ===== hdl/gsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the gradient stop palette.
// Used by every module of the block; depends on nothing.
package gsp_pkg;

  localparam int MAX_STOPS  = 8;
  localparam int IDX_W      = $clog2(MAX_STOPS);
  localparam int N_W        = $clog2(MAX_STOPS + 1);
  localparam int CNT_W      = 4;
  localparam int PADDR_W    = 2;

  // job queue between front and back
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // result queue at the back end
  localparam int ODEPTH     = 16;
  localparam int OPTR_W     = $clog2(ODEPTH);

  // divider: 16 quotient bits, two per stage
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = 16 / DIV_BPS;
  localparam int BACK_DEPTH = DIV_STAGES + 2;

  localparam logic [PADDR_W-1:0] ADDR_STOP_COUNT = 2'd0;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  localparam logic [15:0] COLOR_BLACK = 16'h0000;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stop_t;

  typedef struct packed {
    logic [7:0] idx;
    stop_t      a;
    stop_t      b;
    logic       short_f;
  } job_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] dq;
  } div_t;

  // Side data that travels alongside the divider lanes
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] neg;
    logic       zero_span;
    logic       short_f;
  } side_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic div_t div_step(input div_t cur, input logic [7:0] dv);
    logic [8:0] trial;
    div_t       res;
    trial  = {cur.rem, cur.dq[15]};
    res.dq = {cur.dq[14:0], 1'b0};
    if (trial >= {1'b0, dv}) begin
      trial     = trial - {1'b0, dv};
      res.dq[0] = 1'b1;
    end
    res.rem = trial[7:0];
    return res;
  endfunction

  // Round an 8-bit channel to k levels: (c*k + 127) / 255 via reciprocal
  function automatic logic [5:0] scale_chan(input logic [7:0] c, input logic [5:0] k);
    logic [15:0] x;
    logic [15:0] q;
    x = 16'(c) * 16'(k) + 16'd127;
    q = (x + 16'(x[15:8]) + 16'd1) >> 8;
    return q[5:0];
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [5:0] r5;
    logic [5:0] g6;
    logic [5:0] b5;
    r5 = scale_chan(r, 6'd31);
    g6 = scale_chan(g, 6'd63);
    b5 = scale_chan(b, 6'd31);
    return {r5[4:0], g6, b5[4:0]};
  endfunction

endpackage

// ===== hdl/gsp_div.sv =====
`timescale 1ns / 1ps
// Pipelined unsigned 16-by-8 divider lane, two quotient bits per stage.
// Depends on gsp_pkg for the step function and stage count.
module gsp_div (
  input  logic        clk,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic [15:0] quotient
);

  gsp_pkg::div_t stg_r   [gsp_pkg::DIV_STAGES];
  gsp_pkg::div_t stg_nxt [gsp_pkg::DIV_STAGES];
  logic [7:0]    dv_r    [gsp_pkg::DIV_STAGES];

  // run two steps per stage on the previous stage's partial result
  always_comb begin
    gsp_pkg::div_t cur;
    logic [7:0]    dv;
    for (int s = 0; s < gsp_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        cur.rem = '0;
        cur.dq  = dividend;
        dv      = divisor;
      end else begin
        cur = stg_r[s-1];
        dv  = dv_r[s-1];
      end
      for (int b = 0; b < gsp_pkg::DIV_BPS; b++) begin
        cur = gsp_pkg::div_step(cur, dv);
      end
      stg_nxt[s] = cur;
    end
  end

  // advance every cycle
  always_ff @(posedge clk) begin
    dv_r[0] <= divisor;
    for (int s = 1; s < gsp_pkg::DIV_STAGES; s++) begin
      dv_r[s] <= dv_r[s-1];
    end
    for (int s = 0; s < gsp_pkg::DIV_STAGES; s++) begin
      stg_r[s] <= stg_nxt[s];
    end
  end

  assign quotient = stg_r[gsp_pkg::DIV_STAGES-1].dq;

endmodule

// ===== hdl/gsp_front.sv =====
`timescale 1ns / 1ps
// Front end: input handshake, stop table, stop count register and segment search.
// Depends on gsp_pkg; feeds render jobs to the job queue.
module gsp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [2:0]                  in_stop_slot,
  input  logic [7:0]                  in_stop_pos,
  input  logic [7:0]                  in_stop_red,
  input  logic [7:0]                  in_stop_green,
  input  logic [7:0]                  in_stop_blue,
  input  logic [7:0]                  in_entry_index,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  input  logic [gsp_pkg::QPTR_W:0]    q_count,
  output logic                        job_valid,
  output gsp_pkg::job_t               job
);

  logic [gsp_pkg::CNT_W-1:0] count_r;
  logic                      job_valid_r;
  logic [7:0]                pos_r    [gsp_pkg::MAX_STOPS];
  gsp_pkg::stop_t            stop_mem [gsp_pkg::MAX_STOPS];
  gsp_pkg::stop_t            rd_a_r;
  gsp_pkg::stop_t            rd_b_r;
  logic [7:0]                idx_r;
  logic                      short_r;

  logic                      in_acc;
  logic [gsp_pkg::N_W-1:0]   n_eff;
  logic [gsp_pkg::IDX_W-1:0] seg;
  logic [gsp_pkg::IDX_W-1:0] seg_b;
  logic                      slot_ok;

  // leave room for the job still in the read stage
  assign in_ready = (int'(q_count) + int'(job_valid_r)) < gsp_pkg::QDEPTH;
  assign in_acc   = in_valid && in_ready;
  assign slot_ok  = int'(in_stop_slot) < gsp_pkg::MAX_STOPS;

  // count interior stops that lie below the requested entry
  always_comb begin
    n_eff = (int'(count_r) > gsp_pkg::MAX_STOPS) ? gsp_pkg::N_W'(gsp_pkg::MAX_STOPS)
                                                 : gsp_pkg::N_W'(count_r);
    seg = '0;
    for (int k = 1; k < gsp_pkg::MAX_STOPS - 1; k++) begin
      if ((k + 1 < int'(n_eff)) && (pos_r[k] < in_entry_index)) begin
        seg = seg + 1'b1;
      end
    end
    seg_b = seg + 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr == gsp_pkg::ADDR_STOP_COUNT)) begin
        count_r <= pwdata[gsp_pkg::CNT_W-1:0];
      end
      job_valid_r <= in_acc && (in_kind == gsp_pkg::KIND_RENDER);
    end
  end

  // stop table: write on a write word, read both ends of the segment on a render word
  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == gsp_pkg::KIND_WRITE) && slot_ok) begin
      stop_mem[gsp_pkg::IDX_W'(in_stop_slot)] <= '{pos: in_stop_pos, red: in_stop_red,
                                                   green: in_stop_green, blue: in_stop_blue};
      pos_r[gsp_pkg::IDX_W'(in_stop_slot)]    <= in_stop_pos;
    end
    if (in_acc && (in_kind == gsp_pkg::KIND_RENDER)) begin
      rd_a_r  <= stop_mem[seg];
      rd_b_r  <= stop_mem[seg_b];
      idx_r   <= in_entry_index;
      short_r <= n_eff < gsp_pkg::N_W'(2);
    end
  end

  assign prdata    = (paddr == gsp_pkg::ADDR_STOP_COUNT) ? {28'd0, count_r} : 32'd0;
  assign job_valid = job_valid_r;
  assign job       = '{idx: idx_r, a: rd_a_r, b: rd_b_r, short_f: short_r};

endmodule

// ===== hdl/gsp_jobq.sv =====
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on gsp_pkg for the job type and depth.
module gsp_jobq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  gsp_pkg::job_t            push_job,
  input  logic                     pop,
  output logic                     not_empty,
  output gsp_pkg::job_t            head,
  output logic [gsp_pkg::QPTR_W:0] count
);

  gsp_pkg::job_t             q_r [gsp_pkg::QDEPTH];
  logic [gsp_pkg::QPTR_W-1:0] wptr_r;
  logic [gsp_pkg::QPTR_W-1:0] rptr_r;
  logic [gsp_pkg::QPTR_W:0]   count_r;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (gsp_pkg::QPTR_W+1)'(push) - (gsp_pkg::QPTR_W+1)'(pop);
    end
  end

  // hold job payloads
  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= push_job;
  end

  assign not_empty = count_r != '0;
  assign head      = q_r[rptr_r];
  assign count     = count_r;

endmodule

// ===== hdl/gsp_back.sv =====
`timescale 1ns / 1ps
// Back end: interpolation multiply, three divider lanes, RGB565 packing, result queue.
// Depends on gsp_pkg and gsp_div.
module gsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  gsp_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_color_565
);

  localparam int LAST = gsp_pkg::BACK_DEPTH - 1;

  logic                       v_r    [gsp_pkg::BACK_DEPTH];
  gsp_pkg::side_t             side_r [gsp_pkg::BACK_DEPTH];
  logic signed [17:0]         prod_r [3];
  logic signed [8:0]          span_r;
  logic [15:0]                mag_r  [3];
  logic [7:0]                 smag_r;
  logic [15:0]                quo    [3];

  logic [gsp_pkg::OPTR_W:0]   outst_r;
  logic [15:0]                ofifo  [gsp_pkg::ODEPTH];
  logic [gsp_pkg::OPTR_W-1:0] owptr_r;
  logic [gsp_pkg::OPTR_W-1:0] orptr_r;
  logic [gsp_pkg::OPTR_W:0]   ocnt_r;

  logic                       out_acc;
  logic signed [8:0]          t_s;
  logic signed [8:0]          span_s;
  logic signed [8:0]          diff_s [3];
  logic [7:0]                 a_ch   [3];
  logic [7:0]                 b_ch   [3];
  logic [7:0]                 fin_ch [3];
  logic [15:0]                fin_color;

  // take a job only when a result slot is guaranteed
  assign job_pop = job_valid && (int'(outst_r) < gsp_pkg::ODEPTH);
  assign out_acc = out_valid && out_ready;

  // differences and position offsets, signed
  always_comb begin
    a_ch[0] = job.a.red;   b_ch[0] = job.b.red;
    a_ch[1] = job.a.green; b_ch[1] = job.b.green;
    a_ch[2] = job.a.blue;  b_ch[2] = job.b.blue;
    t_s    = $signed({1'b0, job.idx})   - $signed({1'b0, job.a.pos});
    span_s = $signed({1'b0, job.b.pos}) - $signed({1'b0, job.a.pos});
    for (int c = 0; c < 3; c++) begin
      diff_s[c] = $signed({1'b0, b_ch[c]}) - $signed({1'b0, a_ch[c]});
    end
  end

  // valid bits and credit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < gsp_pkg::BACK_DEPTH; s++) v_r[s] <= 1'b0;
      outst_r <= '0;
    end else begin
      v_r[0] <= job_pop;
      for (int s = 1; s < gsp_pkg::BACK_DEPTH; s++) v_r[s] <= v_r[s-1];
      outst_r <= outst_r + (gsp_pkg::OPTR_W+1)'(job_pop) - (gsp_pkg::OPTR_W+1)'(out_acc);
    end
  end

  // multiply, then magnitude and sign, then carry side data along the divider
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= diff_s[c] * t_s;
      mag_r[c]  <= prod_r[c][17] ? 16'(-prod_r[c]) : prod_r[c][15:0];
    end
    span_r <= span_s;
    smag_r <= span_r[8] ? 8'(-span_r) : span_r[7:0];
    side_r[0] <= '{red: job.a.red, green: job.a.green, blue: job.a.blue, neg: 3'b000,
                   zero_span: (span_s == 9'sd0), short_f: job.short_f};
    side_r[1] <= '{red: side_r[0].red, green: side_r[0].green, blue: side_r[0].blue,
                   neg: {prod_r[2][17] ^ span_r[8], prod_r[1][17] ^ span_r[8],
                         prod_r[0][17] ^ span_r[8]},
                   zero_span: side_r[0].zero_span, short_f: side_r[0].short_f};
    for (int s = 2; s < gsp_pkg::BACK_DEPTH; s++) side_r[s] <= side_r[s-1];
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    gsp_div u_div (
      .clk      (clk),
      .dividend (mag_r[c]),
      .divisor  (smag_r),
      .quotient (quo[c])
    );
  end

  // apply the signed step and pack
  always_comb begin
    logic [7:0] base [3];
    logic [7:0] step;
    base[0] = side_r[LAST].red;
    base[1] = side_r[LAST].green;
    base[2] = side_r[LAST].blue;
    for (int c = 0; c < 3; c++) begin
      step      = side_r[LAST].neg[c] ? 8'(-quo[c][7:0]) : quo[c][7:0];
      fin_ch[c] = side_r[LAST].zero_span ? base[c] : base[c] + step;
    end
    fin_color = side_r[LAST].short_f ? gsp_pkg::COLOR_BLACK
                                     : gsp_pkg::pack565(fin_ch[0], fin_ch[1], fin_ch[2]);
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (v_r[LAST]) owptr_r <= owptr_r + 1'b1;
      if (out_acc)   orptr_r <= orptr_r + 1'b1;
      ocnt_r <= ocnt_r + (gsp_pkg::OPTR_W+1)'(v_r[LAST]) - (gsp_pkg::OPTR_W+1)'(out_acc);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (v_r[LAST]) ofifo[owptr_r] <= fin_color;
  end

  assign out_valid     = ocnt_r != '0;
  assign out_color_565 = ofifo[orptr_r];

endmodule

// ===== hdl/gradient_stop_palette_rgb565.sv =====
`timescale 1ns / 1ps
// Gradient stop palette to RGB565. Accepts stop writes or renders, one word per cycle
// while in_ready is high. A render word passes the front read stage, the job queue, the
// multiply, the magnitude, eight divider stages and the result queue before out_valid.
// Throughput: one word per cycle while in_ready is high; a write word gives no result.
// Synchronous active-low reset clears stop_count, queues and valids; stop table is not cleared.
module gradient_stop_palette_rgb565 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [2:0]                  in_stop_slot,
  input  logic [7:0]                  in_stop_pos,
  input  logic [7:0]                  in_stop_red,
  input  logic [7:0]                  in_stop_green,
  input  logic [7:0]                  in_stop_blue,
  input  logic [7:0]                  in_entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_color_565,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                    f_valid;
  gsp_pkg::job_t           f_job;
  logic                    q_not_empty;
  gsp_pkg::job_t           q_head;
  logic [gsp_pkg::QPTR_W:0] q_count;
  logic                    q_pop;

  assign pready = 1'b1;

  gsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_stop_slot   (in_stop_slot),
    .in_stop_pos    (in_stop_pos),
    .in_stop_red    (in_stop_red),
    .in_stop_green  (in_stop_green),
    .in_stop_blue   (in_stop_blue),
    .in_entry_index (in_entry_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .q_count        (q_count),
    .job_valid      (f_valid),
    .job            (f_job)
  );

  gsp_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_job  (f_job),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  gsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_not_empty),
    .job           (q_head),
    .job_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_color_565 (out_color_565)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the gradient stop palette: a directed stimulus table, then random
// gradients and renders, checked against a colour predictor. Depends on gsp_pkg and the RTL.
module tb_top;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic        is_cfg;
    logic [3:0]  cfg_val;
    logic        kind;
    logic [2:0]  slot;
    logic [7:0]  pos;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  idx;
    logic        typed;
    logic [15:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [2:0] in_stop_slot = '0;
  logic [7:0] in_stop_pos = '0;
  logic [7:0] in_stop_red = '0;
  logic [7:0] in_stop_green = '0;
  logic [7:0] in_stop_blue = '0;
  logic [7:0] in_entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_color_565;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gsp_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  gsp_pkg::stop_t stop_mem[gsp_pkg::MAX_STOPS];
  logic [3:0]  stop_count_q = '0;
  logic [15:0] color_q[$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  logic        hold_req = 1'b0;

  int cfg_plan[12] = '{2, 8, 5, 15, 9, 8, 4, 1, 7, 12, 8, 6};

  stim_row_t stim_tbl[24] = '{
    // nothing valid after reset: black
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
      gsp_pkg::COLOR_BLACK},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd5, 8'hff, 8'hff, 8'hff, 8'hff, 8'd255, 1'b1,
      gsp_pkg::COLOR_BLACK},
    // fill every slot
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd1, 8'd255, 8'hff, 8'hff, 8'hff, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd2, 8'd64, 8'hff, 8'h00, 8'h00, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd3, 8'd128, 8'h00, 8'hff, 8'h00, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd4, 8'd192, 8'h00, 8'h00, 8'hff, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd5, 8'd200, 8'h80, 8'h80, 8'h80, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd6, 8'd220, 8'h12, 8'h34, 8'h56, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd7, 8'd255, 8'hff, 8'hff, 8'hff, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd90, 1'b1,
      gsp_pkg::COLOR_BLACK},
    // one stop only: still black
    '{1'b1, 4'd1, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 1'b1,
      gsp_pkg::COLOR_BLACK},
    // two stops: black to white
    '{1'b1, 4'd2, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 16'h0000},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 16'hffff},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd100, 1'b0, 16'h0},
    // zero span: colour of the first stop
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd1, 8'd0, 8'hff, 8'h00, 8'h00, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd77, 1'b1,
      gsp_pkg::COLOR_BLACK},
    // count above the table, unsorted stops
    '{1'b1, 4'd15, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd150, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_WRITE, 3'd0, 8'd200, 8'h40, 8'hc0, 8'h20, 8'd0, 1'b0, 16'h0},
    '{1'b0, 4'd0, gsp_pkg::KIND_RENDER, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 1'b0, 16'h0}
  };

  gradient_stop_palette_rgb565 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_stop_slot(in_stop_slot), .in_stop_pos(in_stop_pos), .in_stop_red(in_stop_red),
    .in_stop_green(in_stop_green), .in_stop_blue(in_stop_blue),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_color_565(out_color_565),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // round one 8-bit channel to the given number of levels
  function automatic int round_chan(input logic [7:0] c, input int levels);
    return (int'(c) * levels + 127) / 255;
  endfunction

  function automatic logic [15:0] rgb_to_565(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = 5'(round_chan(r, 31));
    g6 = 6'(round_chan(g, 63));
    b5 = 5'(round_chan(b, 31));
    return {r5, g6, b5};
  endfunction

  // signed step along the segment, truncated toward zero, low 8 bits kept
  function automatic logic [7:0] blend_chan(input logic [7:0] ca, input logic [7:0] cb,
                                            input int t, input int span);
    int diff;
    int sum;
    diff = int'(cb) - int'(ca);
    sum  = int'(ca) + (diff * t) / span;
    return sum[7:0];
  endfunction

  function automatic logic [15:0] predict_color(input logic [7:0] idx);
    int             n;
    int             seg;
    int             span;
    int             t;
    gsp_pkg::stop_t a;
    gsp_pkg::stop_t b;
    n = (stop_count_q > gsp_pkg::MAX_STOPS) ? gsp_pkg::MAX_STOPS : int'(stop_count_q);
    if (n < 2) return gsp_pkg::COLOR_BLACK;
    seg = 0;
    for (int k = 1; k + 1 < n; k++) begin
      if (stop_mem[k].pos < idx) seg++;
    end
    a = stop_mem[seg];
    b = stop_mem[seg + 1];
    span = int'(b.pos) - int'(a.pos);
    if (span == 0) return rgb_to_565(a.red, a.green, a.blue);
    t = int'(idx) - int'(a.pos);
    return rgb_to_565(blend_chan(a.red, b.red, t, span), blend_chan(a.green, b.green, t, span),
                      blend_chan(a.blue, b.blue, t, span));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // offer one word, update the predictor when it is taken
  task automatic send_word(input logic kind, input logic [2:0] slot, input logic [7:0] pos,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] idx, input logic typed, input logic [15:0] want);
    int gap;
    @(negedge clk);
    in_valid       = 1'b1;
    in_kind        = kind;
    in_stop_slot   = slot;
    in_stop_pos    = pos;
    in_stop_red    = r;
    in_stop_green  = g;
    in_stop_blue   = b;
    in_entry_index = idx;
    do @(posedge clk); while (!in_ready);
    if (kind == gsp_pkg::KIND_WRITE) begin
      stop_mem[slot] = '{pos: pos, red: r, green: g, blue: b};
    end else begin
      color_q.push_back(typed ? want : predict_color(idx));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid, then hold until every expected colour has come out and the pipe is drained
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_stop_count(input logic [3:0] val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = gsp_pkg::ADDR_STOP_COUNT;
    pwdata  = {28'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    stop_count_q = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_random_render();
    send_word(gsp_pkg::KIND_RENDER, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 1'b0, 16'h0);
  endtask

  // mostly sorted gradients followed by renders, with stray writes and renders mixed in
  task automatic run_random(input int items);
    int sent;
    int sel;
    int n;
    int p;
    int renders;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        n = $urandom_range(2, gsp_pkg::MAX_STOPS);
        p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        for (int s = 0; s < n; s++) begin
          send_word(gsp_pkg::KIND_WRITE, 3'(s), 8'(p), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 1'b0, 16'h0);
          p = p + $urandom_range(0, 70);
          if (p > 255) p = 255;
        end
        renders = $urandom_range(8, 30);
        repeat (renders) send_random_render();
        sent += n + renders;
      end else if (sel < 30) begin
        send_word(gsp_pkg::KIND_WRITE, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'b0, 16'h0);
        sent++;
      end else begin
        send_random_render();
        sent++;
      end
    end
  endtask

  // result side: random stalls, ready stretches, and one long hold-off on request
  initial begin
    int run_left;
    int mode;
    run_left = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 9);
          run_left = (mode < 3) ? $urandom_range(20, 80) :
                     (mode < 9) ? $urandom_range(10, 40) : $urandom_range(5, 40);
        end
        run_left--;
        out_ready = (mode < 3) ? 1'b1 : (mode < 9) ? ($urandom_range(0, 3) != 0) : 1'b0;
      end
    end
  end

  // compare each colour taken against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        $display("%0t: unexpected colour %h", $time, out_color_565);
        err_cnt++;
      end else begin
        if (out_color_565 !== color_q[0]) begin
          $display("%0t: colour mismatch, expected %h, got %h", $time, color_q[0],
                   out_color_565);
          err_cnt++;
        end
        void'(color_q.pop_front());
      end
    end
  end

  // stop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].is_cfg) begin
        wait_idle();
        write_stop_count(stim_tbl[i].cfg_val);
      end else begin
        send_word(stim_tbl[i].kind, stim_tbl[i].slot, stim_tbl[i].pos, stim_tbl[i].red,
                  stim_tbl[i].green, stim_tbl[i].blue, stim_tbl[i].idx, stim_tbl[i].typed,
                  stim_tbl[i].want);
      end
    end

    // random phases, one stop count each
    foreach (cfg_plan[ph]) begin
      wait_idle();
      write_stop_count(4'(cfg_plan[ph]));
      if (ph == 1) hold_req = 1'b1;
      run_random(140);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gsp_pkg.sv
hdl/gsp_div.sv
hdl/gsp_front.sv
hdl/gsp_jobq.sv
hdl/gsp_back.sv
hdl/gradient_stop_palette_rgb565.sv
sim/tb_top.sv
